### hdl/bright_spot_dilate_patch_top_macros.svh
// Assertion macros shared by the bright spot patch RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BRIGHT_SPOT_DILATE_PATCH_TOP_MACROS_SVH
`define BRIGHT_SPOT_DILATE_PATCH_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSDP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BSDP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bsdp_pkg.sv
// Package for the bright spot dilate and patch block: field widths, reset values,
// register codes and the pixel and result queue types. No dependencies.
package bsdp_pkg;

  localparam int CH_W       = 8;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 10;
  localparam int STRIP_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Result queue geometry.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  // Register reset values and fixed channel values.
  localparam logic [FW_W-1:0]    FW_RESET     = 10'd320;
  localparam logic [ROW_W-1:0]   FH_RESET     = 12'd200;
  localparam logic [STRIP_W-1:0] STRIP_RESET  = 6'd0;
  localparam logic [CH_W-1:0]    THR_RESET    = 8'd180;
  localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_STRIP_ROWS   = 2'd2,
    REG_THRESHOLD    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  // One queued input item: an optional cleaned strip pixel, then the pixel itself.
  typedef struct packed {
    logic              has_first;
    pixel_t            first_pix;
    logic [ROW_W-1:0]  first_row;
    pixel_t            pix;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              done;
  } res_entry_t;

endpackage

### hdl/bsdp_in_if.sv
// Input pixel channel: valid/ready handshake carrying one RGBA pixel.
// Depends on nothing.
interface bsdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

### hdl/bsdp_out_if.sv
// Result channel: valid/ready handshake carrying a positioned RGBA pixel.
// Depends on bsdp_pkg for the coordinate widths.
interface bsdp_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsdp_pkg::COL_W-1:0]  column;
  logic [bsdp_pkg::ROW_W-1:0]  row;
  logic [7:0]                  red_out;
  logic [7:0]                  green_out;
  logic [7:0]                  blue_out;
  logic [7:0]                  alpha_out;
  logic                        run_last;
  logic                        frame_done;

  modport source (output valid, column, row, red_out, green_out, blue_out, alpha_out,
                  run_last, frame_done, input ready);
  modport sink (input valid, column, row, red_out, green_out, blue_out, alpha_out,
                run_last, frame_done, output ready);
endinterface

### hdl/bright_spot_dilate_patch_top.sv
// Bright spot dilate and patch, top level. A result passes the second stage register and
// the result queue before it appears. Stored and passing pixels sustain one transaction
// per cycle while the result queue has room; pixels of the second strip give two results
// each on the single result port. Strip storage is synchronous memory, no clearing pass.
// Reset (asynchronous, active low) restores the register defaults and the frame position.
`include "bright_spot_dilate_patch_top_macros.svh"

module bright_spot_dilate_patch_top #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_STRIP = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsdp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsdp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bsdp_in_if.sink                         pix_in,
  bsdp_out_if.source                      pix_out
);
  import bsdp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WLW = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WLW > FW_W) ? WLW : FW_W;
  localparam int SW  = (MAX_STRIP > 1) ? $clog2(MAX_STRIP) : 1;
  localparam int YW  = ROW_W + 1;
  localparam logic [EW-1:0] MAX_W_E     = EW'(MAX_WIDTH);
  localparam logic [8:0]    MAX_STRIP_E = 9'(MAX_STRIP);

  // Configuration registers.
  logic [FW_W-1:0]    fw_q;
  logic [ROW_W-1:0]   fh_q;
  logic [STRIP_W-1:0] strip_q;
  logic [CH_W-1:0]    thr_q;

  // Frame position.
  logic [CW-1:0]      col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;

  // Input stage signals.
  logic               in_fire;
  logic [EW-1:0]      eff_w;
  logic [ROW_W-1:0]   eff_h;
  logic               col_wrap;
  logic [CW-1:0]      x;
  logic [YW-1:0]      y_ext;
  logic [ROW_W-1:0]   y;
  logic [EW-1:0]      x_inc;
  logic [YW-1:0]      y_inc;
  logic               in_done;
  logic [STRIP_W:0]   two_s;
  logic               pass;
  logic               in_late;
  logic               in_store;
  logic               in_patch;
  logic [ROW_W-1:0]   row0;
  logic               in_mark;
  pixel_t             in_pix;

  // Second stage registers.
  logic               s1_valid_q;
  logic               s1_patch_q;
  logic [CW-1:0]      s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [ROW_W-1:0]   s1_row0_q;
  pixel_t             s1_pix_q;
  logic               s1_done_q;
  logic               s1_nxt_ok_q;
  logic               prev_mark_q;

  // Memory and queue connections.
  pixel_t             rd_pix;
  logic               mark_cur;
  logic               mark_nxt;
  logic               dilated;
  res_entry_t         push_data;
  logic [QCNT_W-1:0]  q_count;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q    <= FW_RESET;
      fh_q    <= FH_RESET;
      strip_q <= STRIP_RESET;
      thr_q   <= THR_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  fw_q    <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q    <= cfg_data_i[ROW_W-1:0];
        REG_STRIP_ROWS:   strip_q <= cfg_data_i[STRIP_W-1:0];
        REG_THRESHOLD:    thr_q   <= cfg_data_i[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, pixel position and the class of the arriving pixel.
  always_comb begin
    in_pix = '{alpha: pix_in.alpha, blue: pix_in.blue, green: pix_in.green,
               red: pix_in.red};
    if (fw_q == '0) begin
      eff_w = EW'(1);
    end else if (EW'(fw_q) > MAX_W_E) begin
      eff_w = MAX_W_E;
    end else begin
      eff_w = EW'(fw_q);
    end
    eff_h = (fh_q == '0) ? ROW_W'(1) : fh_q;

    // A position left beyond a shrunk frame wraps before use.
    col_wrap = (EW'(col_q) >= eff_w);
    x        = col_wrap ? '0 : col_q;
    y_ext    = col_wrap ? (YW'(row_q) + YW'(1)) : YW'(row_q);
    y        = (y_ext >= YW'(eff_h)) ? '0 : y_ext[ROW_W-1:0];

    x_inc   = EW'(x) + EW'(1);
    y_inc   = YW'(y) + YW'(1);
    in_done = (x_inc == eff_w) && (y_inc == YW'(eff_h));

    two_s    = (STRIP_W + 1)'(strip_q) << 1;
    pass     = (strip_q == '0) || (9'(strip_q) > MAX_STRIP_E) || (ROW_W'(two_s) > eff_h);
    in_late  = pass || (y >= ROW_W'(two_s));
    in_store = !in_late && (y < ROW_W'(strip_q));
    in_patch = !in_late && !in_store;
    row0     = y - ROW_W'(strip_q);
    in_mark  = (pix_in.red > thr_q) && (pix_in.green > thr_q) && (pix_in.blue > thr_q);

    // Position of the next pixel.
    if (x_inc >= eff_w) begin
      col_d = '0;
      row_d = (y_inc >= YW'(eff_h)) ? '0 : y_inc[ROW_W-1:0];
    end else begin
      col_d = x_inc[CW-1:0];
      row_d = y;
    end
  end

  // Room is kept for the item in the second stage and the one being taken.
  assign pix_in.ready = ((QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_q))
                        < (QCNT_W + 1)'(QDEPTH);
  assign in_fire = pix_in.valid && pix_in.ready;

  // Position counters and second stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s1_patch_q  <= 1'b0;
      prev_mark_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= in_fire && !in_store;
      s1_patch_q <= in_fire && in_patch;
      // The column to the left of the next patched pixel.
      if (s1_valid_q && s1_patch_q) begin
        prev_mark_q <= mark_cur;
      end
    end
  end

  // Second stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_col_q    <= x;
      s1_row_q    <= y;
      s1_row0_q   <= row0;
      s1_pix_q    <= in_pix;
      s1_done_q   <= in_done;
      s1_nxt_ok_q <= (x_inc < eff_w);
    end
  end

  bsdp_strip_mem #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_STRIP (MAX_STRIP)
  ) u_strip_mem (
    .clk_i      (clk_i),
    .wr_en_i    (in_fire && in_store),
    .wr_row_i   (SW'(y)),
    .wr_col_i   (x),
    .wr_pix_i   (in_pix),
    .wr_mark_i  (in_mark),
    .rd_en_i    (in_fire && in_patch),
    .rd_row_i   (SW'(row0)),
    .rd_col_i   (x),
    .rd_pix_o   (rd_pix),
    .mark_cur_o (mark_cur),
    .mark_nxt_o (mark_nxt)
  );

  // Horizontal part of the 3x3 dilation, clipped at both frame edges, and the patch.
  always_comb begin
    dilated = mark_cur || (s1_nxt_ok_q && mark_nxt) || ((s1_col_q != '0) && prev_mark_q);
    push_data.has_first = s1_patch_q;
    push_data.first_pix = dilated ? '{alpha: ALPHA_OPAQUE, blue: s1_pix_q.blue,
                                      green: s1_pix_q.green, red: s1_pix_q.red}
                                  : rd_pix;
    push_data.first_row = s1_row0_q;
    push_data.pix       = s1_pix_q;
    push_data.col       = COL_W'(s1_col_q);
    push_data.row       = s1_row_q;
    push_data.done      = s1_done_q;
  end

  bsdp_res_queue u_res_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q),
    .push_data_i (push_data),
    .count_o     (q_count),
    .out_if      (pix_out)
  );

  `BSDP_ASSERT(a_row0_in_strip, (s1_valid_q && s1_patch_q) |-> (s1_row0_q < ROW_W'(MAX_STRIP)), "source row outside strip store")
  `BSDP_ASSERT_NEXT(a_store_silent, (in_fire && in_store), !s1_valid_q, "stored pixel produced a result")

endmodule

### hdl/bsdp_strip_mem.sv
// Strip storage: the pixel memory and the column-organised bright mark memory.
// Depends on bsdp_pkg for the pixel type.
module bsdp_strip_mem #(
  parameter int MAX_WIDTH = 512,
  parameter int MAX_STRIP = 32,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int SW = (MAX_STRIP > 1) ? $clog2(MAX_STRIP) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [SW-1:0]    wr_row_i,
  input  logic [CW-1:0]    wr_col_i,
  input  bsdp_pkg::pixel_t wr_pix_i,
  input  logic             wr_mark_i,
  input  logic             rd_en_i,
  input  logic [SW-1:0]    rd_row_i,
  input  logic [CW-1:0]    rd_col_i,
  output bsdp_pkg::pixel_t rd_pix_o,
  output logic             mark_cur_o,
  output logic             mark_nxt_o
);
  import bsdp_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_STRIP;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

  // Pixel store, one entry per strip position.
  pixel_t pix_mem [DEPTH];
  // Mark store, one word per column; bit r holds the vertical 3-row OR around row r.
  logic [MAX_STRIP-1:0] mark_mem [MAX_WIDTH];

  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [CW-1:0]        nxt_col;
  logic [MAX_STRIP-1:0] row_sel;
  logic [MAX_STRIP-1:0] wr_mask;
  logic [MAX_STRIP-1:0] cur_word_q;
  logic [MAX_STRIP-1:0] nxt_word_q;
  logic [SW-1:0]        rd_row_q;

  // Address arithmetic and the bit mask of the vertical dilation.
  // Row r writes bit r+1 outright (its first contributor) and sets bits r and r-1
  // when marked; row zero starts bit zero as well.
  always_comb begin
    wr_addr = AW'(wr_row_i) * ROW_STRIDE + AW'(wr_col_i);
    rd_addr = AW'(rd_row_i) * ROW_STRIDE + AW'(rd_col_i);
    nxt_col = rd_col_i + CW'(1);
    row_sel = MAX_STRIP'(1) << wr_row_i;
    if (wr_row_i == '0) begin
      wr_mask = (row_sel << 1) | row_sel;
    end else begin
      wr_mask = (row_sel << 1) | (wr_mark_i ? (row_sel | (row_sel >> 1)) : '0);
    end
  end

  // Write side.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pix_mem[wr_addr] <= wr_pix_i;
      for (int b = 0; b < MAX_STRIP; b++) begin
        if (wr_mask[b]) begin
          mark_mem[wr_col_i][b] <= wr_mark_i;
        end
      end
    end
  end

  // Read side: this column and the next, data registered.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_pix_o   <= pix_mem[rd_addr];
      cur_word_q <= mark_mem[rd_col_i];
      nxt_word_q <= mark_mem[nxt_col];
      rd_row_q   <= rd_row_i;
    end
  end

  assign mark_cur_o = cur_word_q[rd_row_q];
  assign mark_nxt_o = nxt_word_q[rd_row_q];

endmodule

### hdl/bsdp_res_queue.sv
// Result queue: holds up to four items and plays out one or two results per item.
// Depends on bsdp_pkg, bsdp_out_if and the assertion macro header.
`include "bright_spot_dilate_patch_top_macros.svh"

module bsdp_res_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  bsdp_pkg::res_entry_t        push_data_i,
  output logic [bsdp_pkg::QCNT_W-1:0] count_o,
  bsdp_out_if.source                  out_if
);
  import bsdp_pkg::*;

  res_entry_t             entry_q [QDEPTH];
  logic [QPTR_W-1:0]      wr_ptr_q;
  logic [QPTR_W-1:0]      rd_ptr_q;
  logic [QCNT_W-1:0]      cnt_q;
  logic                   sub_q;
  res_entry_t             head;
  logic                   show_first;
  logic                   out_fire;
  logic                   pop;

  assign head       = entry_q[rd_ptr_q];
  assign show_first = head.has_first && !sub_q;
  assign out_fire   = out_if.valid && out_if.ready;
  assign pop        = out_fire && !show_first;
  assign count_o    = cnt_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers, fill level and the position within the head item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      sub_q    <= 1'b0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
      if (out_fire) begin
        sub_q <= show_first;
      end
    end
  end

  // Output transaction drive.
  always_comb begin
    out_if.valid      = (cnt_q != '0);
    out_if.column     = head.col;
    out_if.row        = show_first ? head.first_row : head.row;
    out_if.red_out    = show_first ? head.first_pix.red : head.pix.red;
    out_if.green_out  = show_first ? head.first_pix.green : head.pix.green;
    out_if.blue_out   = show_first ? head.first_pix.blue : head.pix.blue;
    out_if.alpha_out  = show_first ? head.first_pix.alpha : head.pix.alpha;
    out_if.run_last   = !show_first;
    out_if.frame_done = !show_first && head.done;
  end

  `BSDP_ASSERT(a_push_room, push_i |-> (cnt_q < QCNT_W'(QDEPTH)), "push into a full queue")
  `BSDP_ASSERT(a_sub_idle, (cnt_q == '0) |-> !sub_q, "half-played item in an empty queue")

endmodule
